FILE: design/rotary_pair_rotator_macros.svh
// ----------------------------------------------------------------------------
// rotary_pair_rotator_macros.svh
// Assertion macros for the pair rotator. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ROTARY_PAIR_ROTATOR_MACROS_SVH
`define ROTARY_PAIR_ROTATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every edge out of reset
`define RPR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rotary_pair_rotator: assertion failed");

// Condition in one cycle that implies a consequence in the next
`define RPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rotary_pair_rotator: assertion failed");

`else

`define RPR_ASSERT(label, clk, rst_n, prop)
`define RPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared widths, queue item type, queue status and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int POS_BITS    = 32;
	localparam int STEP_BITS   = 16;
	localparam int TICK_BITS   = 8;
	localparam int COEF_BITS   = 16;
	localparam int FRAC_BITS   = 14;
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int SUM_BITS    = PROD_BITS + 2;
	localparam int RND_BITS    = SUM_BITS - FRAC_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	// One classified pair waiting for the arithmetic back end
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] elem_first;
		logic signed [SAMPLE_BITS-1:0] elem_second;
		logic [TICK_BITS-1:0]          tick;
		logic                          negate_sin;
	} rpr_item_t;

	// Queue status seen by the front end and the back end
	typedef struct packed {
		logic full;
		logic empty;
	} rpr_qstat_t;

	// Quarter-wave sine in Q14, 65 entries
	function automatic logic signed [COEF_BITS-1:0] quarter_sine(input logic [6:0] idx);
		logic signed [COEF_BITS-1:0] v;
		case (idx)
			7'd0:  v = 16'sd0;     7'd1:  v = 16'sd402;   7'd2:  v = 16'sd804;
			7'd3:  v = 16'sd1205;  7'd4:  v = 16'sd1606;  7'd5:  v = 16'sd2006;
			7'd6:  v = 16'sd2404;  7'd7:  v = 16'sd2801;  7'd8:  v = 16'sd3196;
			7'd9:  v = 16'sd3590;  7'd10: v = 16'sd3981;  7'd11: v = 16'sd4370;
			7'd12: v = 16'sd4756;  7'd13: v = 16'sd5139;  7'd14: v = 16'sd5520;
			7'd15: v = 16'sd5897;  7'd16: v = 16'sd6270;  7'd17: v = 16'sd6639;
			7'd18: v = 16'sd7005;  7'd19: v = 16'sd7366;  7'd20: v = 16'sd7723;
			7'd21: v = 16'sd8076;  7'd22: v = 16'sd8423;  7'd23: v = 16'sd8765;
			7'd24: v = 16'sd9102;  7'd25: v = 16'sd9434;  7'd26: v = 16'sd9760;
			7'd27: v = 16'sd10080; 7'd28: v = 16'sd10394; 7'd29: v = 16'sd10702;
			7'd30: v = 16'sd11003; 7'd31: v = 16'sd11297; 7'd32: v = 16'sd11585;
			7'd33: v = 16'sd11866; 7'd34: v = 16'sd12140; 7'd35: v = 16'sd12406;
			7'd36: v = 16'sd12665; 7'd37: v = 16'sd12916; 7'd38: v = 16'sd13160;
			7'd39: v = 16'sd13395; 7'd40: v = 16'sd13623; 7'd41: v = 16'sd13842;
			7'd42: v = 16'sd14053; 7'd43: v = 16'sd14256; 7'd44: v = 16'sd14449;
			7'd45: v = 16'sd14635; 7'd46: v = 16'sd14811; 7'd47: v = 16'sd14978;
			7'd48: v = 16'sd15137; 7'd49: v = 16'sd15286; 7'd50: v = 16'sd15426;
			7'd51: v = 16'sd15557; 7'd52: v = 16'sd15679; 7'd53: v = 16'sd15791;
			7'd54: v = 16'sd15893; 7'd55: v = 16'sd15986; 7'd56: v = 16'sd16069;
			7'd57: v = 16'sd16143; 7'd58: v = 16'sd16207; 7'd59: v = 16'sd16261;
			7'd60: v = 16'sd16305; 7'd61: v = 16'sd16340; 7'd62: v = 16'sd16364;
			7'd63: v = 16'sd16379; 7'd64: v = 16'sd16384;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	// Full-wave sine by quadrant symmetry
	function automatic logic signed [COEF_BITS-1:0] rom_sine(input logic [TICK_BITS-1:0] t);
		logic [6:0] idx;
		logic signed [COEF_BITS-1:0] v;
		idx = t[6] ? (7'd64 - {1'b0, t[5:0]}) : {1'b0, t[5:0]};
		v   = quarter_sine(idx);
		return t[7] ? -v : v;
	endfunction

endpackage

`default_nettype wire

FILE: design/rpr_front.sv
// ----------------------------------------------------------------------------
// rpr_front
// Accepts input pairs, works out the phase tick and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_front (
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [rpr_pkg::SAMPLE_BITS-1:0] elem_first,
	input  wire logic signed [rpr_pkg::SAMPLE_BITS-1:0] elem_second,
	input  wire logic [rpr_pkg::POS_BITS-1:0]          position,
	input  wire logic [rpr_pkg::STEP_BITS-1:0]         tick_step,
	input  wire logic                                  negate_sin,
	input  wire rpr_pkg::rpr_qstat_t                   qstat,
	output logic                                       push,
	output rpr_pkg::rpr_item_t                         item
);

	logic [2*rpr_pkg::TICK_BITS-1:0] tick_prod;

	// Hold off the source while the queue is full
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	// Phase tick: only the low byte of each operand reaches the low byte of the product
	assign tick_prod = position[rpr_pkg::TICK_BITS-1:0] * tick_step[rpr_pkg::TICK_BITS-1:0];

	always_comb begin
		item.elem_first  = elem_first;
		item.elem_second = elem_second;
		item.tick        = tick_prod[rpr_pkg::TICK_BITS-1:0];
		item.negate_sin  = negate_sin;
	end

endmodule

`default_nettype wire

FILE: design/rpr_queue.sv
// ----------------------------------------------------------------------------
// rpr_queue
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotary_pair_rotator_macros.svh"

module rpr_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire rpr_pkg::rpr_item_t  push_item,
	input  wire logic                pop,
	output rpr_pkg::rpr_item_t       pop_item,
	output rpr_pkg::rpr_qstat_t      qstat
);

	rpr_pkg::rpr_item_t                  entry_q [rpr_pkg::QUEUE_DEPTH];
	logic [rpr_pkg::PTR_BITS-1:0]        wr_ptr_q;
	logic [rpr_pkg::PTR_BITS-1:0]        rd_ptr_q;
	logic [rpr_pkg::CNT_BITS-1:0]        count_q;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= rpr_pkg::PTR_BITS'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= rpr_pkg::PTR_BITS'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= rpr_pkg::CNT_BITS'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= rpr_pkg::CNT_BITS'(count_q - 1'b1);
			end
		end
	end

	assign pop_item    = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == rpr_pkg::CNT_BITS'(rpr_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	`RPR_ASSERT(a_no_overflow, clk, arst_n, push |-> !qstat.full)
	`RPR_ASSERT(a_no_underflow, clk, arst_n, pop |-> !qstat.empty)
	`RPR_ASSERT(a_count_bound, clk, arst_n, count_q <= rpr_pkg::CNT_BITS'(rpr_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

FILE: design/rpr_back.sv
// ----------------------------------------------------------------------------
// rpr_back
// Looks up cosine and sine, rotates the pair, rounds and saturates the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotary_pair_rotator_macros.svh"

module rpr_back (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire rpr_pkg::rpr_qstat_t                    qstat,
	input  wire rpr_pkg::rpr_item_t                     pop_item,
	output logic                                        pop,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [rpr_pkg::SAMPLE_BITS-1:0]      rot_first,
	output logic signed [rpr_pkg::SAMPLE_BITS-1:0]      rot_second,
	output logic [rpr_pkg::TICK_BITS-1:0]               phase_tick,
	output logic                                        clipped
);

	localparam logic signed [rpr_pkg::SUM_BITS-1:0] RoundHalf =
		rpr_pkg::SUM_BITS'(1 << (rpr_pkg::FRAC_BITS - 1));
	localparam logic signed [rpr_pkg::RND_BITS-1:0] SatHi =
		rpr_pkg::RND_BITS'((1 << (rpr_pkg::SAMPLE_BITS - 1)) - 1);
	localparam logic signed [rpr_pkg::RND_BITS-1:0] SatLo = ~SatHi;
	localparam logic signed [rpr_pkg::SAMPLE_BITS-1:0] OutHi = SatHi[rpr_pkg::SAMPLE_BITS-1:0];
	localparam logic signed [rpr_pkg::SAMPLE_BITS-1:0] OutLo = SatLo[rpr_pkg::SAMPLE_BITS-1:0];

	logic advance;

	logic                                   valid_s1;
	logic signed [rpr_pkg::SAMPLE_BITS-1:0] a_s1, b_s1;
	logic signed [rpr_pkg::COEF_BITS-1:0]   cos_s1, sin_s1;
	logic [rpr_pkg::TICK_BITS-1:0]          tick_s1;

	logic                                   valid_s2;
	logic signed [rpr_pkg::PROD_BITS-1:0]   ac_s2, bs_s2, as_s2, bc_s2;
	logic [rpr_pkg::TICK_BITS-1:0]          tick_s2;

	logic signed [rpr_pkg::COEF_BITS-1:0]   sin_raw, cos_raw, sin_sel;
	logic signed [rpr_pkg::SUM_BITS-1:0]    sum_first, sum_second;
	logic signed [rpr_pkg::RND_BITS-1:0]    rnd_first, rnd_second;
	logic signed [rpr_pkg::SAMPLE_BITS-1:0] sat_first, sat_second;
	logic                                   clip_first, clip_second;

	logic                                   out_valid_q;
	logic signed [rpr_pkg::SAMPLE_BITS-1:0] rot_first_q, rot_second_q;
	logic [rpr_pkg::TICK_BITS-1:0]          phase_tick_q;
	logic                                   clipped_q;

	// Move the whole pipeline unless the output item is held
	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && !qstat.empty;

	// Look up coefficients, negate sine on request
	always_comb begin
		sin_raw = rpr_pkg::rom_sine(pop_item.tick);
		cos_raw = rpr_pkg::rom_sine(rpr_pkg::TICK_BITS'(pop_item.tick + 8'd64));
		sin_sel = pop_item.negate_sin ? -sin_raw : sin_raw;
	end

	// Valid flags of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Stage 1: pair and coefficients
	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1    <= pop_item.elem_first;
			b_s1    <= pop_item.elem_second;
			cos_s1  <= cos_raw;
			sin_s1  <= sin_sel;
			tick_s1 <= pop_item.tick;
		end
	end

	// Stage 2: four products
	always_ff @(posedge clk) begin
		if (advance) begin
			ac_s2   <= a_s1 * cos_s1;
			bs_s2   <= b_s1 * sin_s1;
			as_s2   <= a_s1 * sin_s1;
			bc_s2   <= b_s1 * cos_s1;
			tick_s2 <= tick_s1;
		end
	end

	// Combine, round half up, saturate
	always_comb begin
		sum_first  = rpr_pkg::SUM_BITS'(ac_s2) - rpr_pkg::SUM_BITS'(bs_s2) + RoundHalf;
		sum_second = rpr_pkg::SUM_BITS'(as_s2) + rpr_pkg::SUM_BITS'(bc_s2) + RoundHalf;
		rnd_first  = sum_first[rpr_pkg::SUM_BITS-1:rpr_pkg::FRAC_BITS];
		rnd_second = sum_second[rpr_pkg::SUM_BITS-1:rpr_pkg::FRAC_BITS];
		clip_first  = (rnd_first > SatHi) || (rnd_first < SatLo);
		clip_second = (rnd_second > SatHi) || (rnd_second < SatLo);
		if (rnd_first > SatHi) begin
			sat_first = OutHi;
		end else if (rnd_first < SatLo) begin
			sat_first = OutLo;
		end else begin
			sat_first = rnd_first[rpr_pkg::SAMPLE_BITS-1:0];
		end
		if (rnd_second > SatHi) begin
			sat_second = OutHi;
		end else if (rnd_second < SatLo) begin
			sat_second = OutLo;
		end else begin
			sat_second = rnd_second[rpr_pkg::SAMPLE_BITS-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance) begin
			rot_first_q  <= sat_first;
			rot_second_q <= sat_second;
			phase_tick_q <= tick_s2;
			clipped_q    <= clip_first || clip_second;
		end
	end

	assign out_valid  = out_valid_q;
	assign rot_first  = rot_first_q;
	assign rot_second = rot_second_q;
	assign phase_tick = phase_tick_q;
	assign clipped    = clipped_q;

	`RPR_ASSERT(a_clip_at_rail, clk, arst_n, (out_valid_q && clipped_q) |-> ((rot_first_q == OutHi) || (rot_first_q == OutLo) || (rot_second_q == OutHi) || (rot_second_q == OutLo)))
	`RPR_ASSERT_NEXT(a_s2_reaches_out, clk, arst_n, valid_s2 && advance, out_valid_q)

endmodule

`default_nettype wire

FILE: design/rotary_pair_rotator.sv
// Path: an accepted item passes through the queue, stage 1, stage 2 and the output register.
// Throughput: one item per cycle while out_stall is low; the four-entry queue and the
// output register decouple the input from the output, so out_stall alone holds the arithmetic pipe.
// Reset (arst_n low, asynchronous): empties the queue and clears every valid flag;
// there is no table to fill and no clearing pass.
// ----------------------------------------------------------------------------
// rotary_pair_rotator
// Rotates signed sample pairs by a ROM phase angle taken from position and step.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_pair_rotator (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [rpr_pkg::SAMPLE_BITS-1:0] elem_first,
	input  wire logic signed [rpr_pkg::SAMPLE_BITS-1:0] elem_second,
	input  wire logic [rpr_pkg::POS_BITS-1:0]           position,
	input  wire logic [rpr_pkg::STEP_BITS-1:0]          tick_step,
	input  wire logic                                   negate_sin,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [rpr_pkg::SAMPLE_BITS-1:0]      rot_first,
	output logic signed [rpr_pkg::SAMPLE_BITS-1:0]      rot_second,
	output logic [rpr_pkg::TICK_BITS-1:0]               phase_tick,
	output logic                                        clipped
);

	rpr_pkg::rpr_qstat_t qstat;
	rpr_pkg::rpr_item_t  push_item;
	rpr_pkg::rpr_item_t  pop_item;
	logic                push;
	logic                pop;

	// Accept and classify
	rpr_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.elem_first  (elem_first),
		.elem_second (elem_second),
		.position    (position),
		.tick_step   (tick_step),
		.negate_sin  (negate_sin),
		.qstat       (qstat),
		.push        (push),
		.item        (push_item)
	);

	// Decouple front and back
	rpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	// Rotate, round and saturate
	rpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rot_first  (rot_first),
		.rot_second (rot_second),
		.phase_tick (phase_tick),
		.clipped    (clipped)
	);

endmodule

`default_nettype wire
